FILE: hdl/bfs_pkg.sv
// shared types and constants for the blend fade sequencer
// register map, channel payload structs and parameter defaults
// no dependencies
package bfs_pkg;

  localparam int TIME_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int NOW_W    = 32;
  localparam int LEVEL_W  = 5;
  localparam int MASK_W   = 14;
  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = $clog2(NUM_REGS) + 2;
  localparam int CFG_DW   = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(16);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_COEF     = 2'd1,
    MODE_BRIGHTEN = 2'd2,
    MODE_DARKEN   = 2'd3
  } blend_mode_t;

  typedef enum logic [1:0] {
    DIR_TO          = 2'd0,
    DIR_FROM        = 2'd1,
    DIR_TO_BACK     = 2'd2,
    DIR_FROM_BACK   = 2'd3
  } direction_t;

  typedef enum logic [2:0] {
    REG_FROM_FIRST  = 3'd0,
    REG_TO_FIRST    = 3'd1,
    REG_FROM_SECOND = 3'd2,
    REG_TO_SECOND   = 3'd3,
    REG_DURATION    = 3'd4,
    REG_MODE        = 3'd5,
    REG_DIRECTION   = 3'd6,
    REG_TARGETS     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [NOW_W-1:0] now_time;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0]  enabled_targets;
    logic [1:0]         active_mode;
    logic [LEVEL_W-1:0] alpha_first;
    logic [LEVEL_W-1:0] alpha_second;
    logic [LEVEL_W-1:0] brightness;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] from_level_first;
    logic [LEVEL_W-1:0] to_level_first;
    logic [LEVEL_W-1:0] from_level_second;
    logic [LEVEL_W-1:0] to_level_second;
    logic [NOW_W-1:0]   fade_duration;
    logic [1:0]         blend_mode;
    logic [1:0]         start_direction;
    logic [MASK_W-1:0]  target_mask;
  } cfg_t;

endpackage

FILE: hdl/bfs_regs.sv
// configuration register bank of the blend fade sequencer
// apb-style write and read, depends on bfs_pkg
module bfs_regs import bfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FROM_FIRST:  cfg_nxt.from_level_first  = pwdata[LEVEL_W-1:0];
        REG_TO_FIRST:    cfg_nxt.to_level_first    = pwdata[LEVEL_W-1:0];
        REG_FROM_SECOND: cfg_nxt.from_level_second = pwdata[LEVEL_W-1:0];
        REG_TO_SECOND:   cfg_nxt.to_level_second   = pwdata[LEVEL_W-1:0];
        REG_DURATION:    cfg_nxt.fade_duration     = pwdata[NOW_W-1:0];
        REG_MODE:        cfg_nxt.blend_mode        = pwdata[1:0];
        REG_DIRECTION:   cfg_nxt.start_direction   = pwdata[1:0];
        REG_TARGETS:     cfg_nxt.target_mask       = pwdata[MASK_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FROM_FIRST:  prdata = CFG_DW'(cfg_r.from_level_first);
      REG_TO_FIRST:    prdata = CFG_DW'(cfg_r.to_level_first);
      REG_FROM_SECOND: prdata = CFG_DW'(cfg_r.from_level_second);
      REG_TO_SECOND:   prdata = CFG_DW'(cfg_r.to_level_second);
      REG_DURATION:    prdata = CFG_DW'(cfg_r.fade_duration);
      REG_MODE:        prdata = CFG_DW'(cfg_r.blend_mode);
      REG_DIRECTION:   prdata = CFG_DW'(cfg_r.start_direction);
      REG_TARGETS:     prdata = CFG_DW'(cfg_r.target_mask);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.from_level_first  <= '0;
      cfg_r.to_level_first    <= LEVEL_MAX;
      cfg_r.from_level_second <= '0;
      cfg_r.to_level_second   <= LEVEL_MAX;
      cfg_r.fade_duration     <= NOW_W'(65536);
      cfg_r.blend_mode        <= MODE_NONE;
      cfg_r.start_direction   <= DIR_TO;
      cfg_r.target_mask       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/blend_fade_sequencer_top.sv
// top level of the blend fade sequencer: fraction divider, level interpolation
// and result sequencing; depends on bfs_pkg and bfs_regs
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  in_t (opcode, now_time)
//  out_*        output     out_valid/out_stall out_t (blend control result)
//  psel..pready config     apb-style, pready=1 cfg_t registers
//
// a tick while armed passes S_SUB, then S_DIV while the fade runs (skipped once
// the time is used up), then S_LVL1, S_LVL2 and S_EMIT, plus S_CLEAR for the
// cleared result at the end of a plain fade; the shared add/compare unit produces
// one quotient bit per cycle and the one multiplier serves both levels
// start items are taken in idle, stop items pass through S_CLEAR; unused opcodes are dropped
// in_stall is high while a tick or stop is in work and while a result waits
// for a full output register; reset clears sequencer state and disarms
module blend_fade_sequencer_top import bfs_pkg::*; #(
  parameter int TIME_WIDTH    = TIME_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int TW   = TIME_WIDTH;
  localparam int FW   = FRACTION_BITS;
  localparam int CNTW = $clog2(FW + 1);
  localparam int VW   = FW + 8;

  typedef enum logic [2:0] {
    S_IDLE, S_SUB, S_DIV, S_LVL1, S_LVL2, S_EMIT, S_CLEAR
  } state_t;

  cfg_t cfg;

  bfs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t             state_r, state_nxt;
  logic               armed_r, armed_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [TW-1:0]      start_r, start_nxt;
  logic [TW-1:0]      now_r, now_nxt;
  logic [TW-1:0]      rem_r, rem_nxt;
  logic [FW:0]        q_r, q_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [LEVEL_W-1:0] lvl1_r, lvl1_nxt, lvl2_r, lvl2_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               accept, slot_free, plain_end;
  logic [TW-1:0]      dur_tw, elapsed;
  logic [TW:0]        rem2;
  logic               ge;
  logic [LEVEL_W-1:0] from_sel, to_sel, lvl_calc;
  logic signed [VW-1:0] diff_s, t_s, prod_s, base_s, v_s;
  logic [7:0]         v_int;
  logic [LEVEL_W-1:0] lvl_clamp;
  out_t               res_val, res_clear;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign dur_tw    = TW'(cfg.fade_duration);
  assign plain_end = done_r & ~dir_r[1];

  // shared add/compare: elapsed time in S_SUB, one quotient bit per cycle in S_DIV
  assign elapsed = now_r - start_r;
  assign rem2    = {rem_r, 1'b0};
  assign ge      = (rem2 >= {1'b0, dur_tw});

  // shared interpolation: from + t*(to-from), clamped to the level range, mirrored for from directions
  always_comb begin
    from_sel  = (state_r == S_LVL2) ? cfg.from_level_second : cfg.from_level_first;
    to_sel    = (state_r == S_LVL2) ? cfg.to_level_second : cfg.to_level_first;
    diff_s    = $signed(VW'(to_sel)) - $signed(VW'(from_sel));
    t_s       = $signed(VW'(q_r));
    prod_s    = VW'(t_s * diff_s);
    base_s    = $signed(VW'(from_sel) << FW);
    v_s       = base_s + prod_s;
    v_int     = v_s[FW+7:FW];
    if (v_s < 0) begin
      lvl_clamp = '0;
    end else if (v_int > 8'(LEVEL_MAX)) begin
      lvl_clamp = LEVEL_MAX;
    end else begin
      lvl_clamp = v_int[LEVEL_W-1:0];
    end
    lvl_calc  = dir_r[0] ? (LEVEL_MAX - lvl_clamp) : lvl_clamp;
  end

  always_comb begin
    res_val                 = '0;
    res_val.enabled_targets = cfg.target_mask;
    res_val.active_mode     = cfg.blend_mode;
    if (cfg.blend_mode == MODE_COEF) begin
      res_val.alpha_first  = lvl1_r;
      res_val.alpha_second = lvl2_r;
    end else begin
      res_val.brightness = lvl1_r;
    end
    res_val.last_result     = ~plain_end;
    res_clear               = '0;
    res_clear.last_result   = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    armed_nxt     = armed_r;
    dir_nxt       = dir_r;
    start_nxt     = start_r;
    now_nxt       = now_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    lvl1_nxt      = lvl1_r;
    lvl2_nxt      = lvl2_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_data.opcode))
            OP_START: begin
              start_nxt = TW'(in_data.now_time);
              dir_nxt   = cfg.start_direction;
              armed_nxt = 1'b1;
            end
            OP_STOP: begin
              armed_nxt = 1'b0;
              state_nxt = S_CLEAR;
            end
            OP_TICK: begin
              if (armed_r) begin
                now_nxt   = TW'(in_data.now_time);
                state_nxt = S_SUB;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SUB: begin
        done_nxt = (elapsed >= dur_tw);
        rem_nxt  = elapsed;
        cnt_nxt  = '0;
        if (elapsed >= dur_tw) begin
          q_nxt     = (FW+1)'(1) << FW;
          state_nxt = S_LVL1;
        end else begin
          q_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // rem stays below the duration, so the doubled value minus it fits
        rem_nxt = ge ? TW'(rem2 - {1'b0, dur_tw}) : rem2[TW-1:0];
        q_nxt   = {q_r[FW-1:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(FW - 1)) begin
          state_nxt = S_LVL1;
        end
      end
      S_LVL1: begin
        lvl1_nxt  = lvl_calc;
        state_nxt = S_LVL2;
      end
      S_LVL2: begin
        lvl2_nxt  = lvl_calc;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_val;
          if (plain_end) begin
            armed_nxt = 1'b0;
            state_nxt = S_CLEAR;
          end else begin
            if (done_r) begin
              // back-and-forth: turn into the plain opposite fade and restart from this tick
              dir_nxt   = (dir_r == DIR_TO_BACK) ? DIR_FROM : DIR_TO;
              start_nxt = now_r;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_clear;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      dir_r       <= DIR_TO;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      dir_r       <= dir_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    done_r     <= done_nxt;
    lvl1_r     <= lvl1_nxt;
    lvl2_r     <= lvl2_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: bench/bfs_fade_checker.sv
// checker for the blend fade sequencer: follows register writes and input transfers,
// predicts the blend control results and compares them with the result channel
// depends on bfs_pkg
`timescale 1ns / 1ps
module bfs_fade_checker import bfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatches,
  output int                outstanding
);

  cfg_t             regs;
  logic [NOW_W-1:0] fade_start;
  direction_t       fade_dir;
  logic             fade_armed;
  out_t             blend_q[$];
  int               err_cnt = 0;

  // elapsed / dur with FRACTION_BITS_DEF fraction bits, elapsed < dur
  function automatic logic [16:0] time_fraction(longint unsigned elapsed,
                                                longint unsigned dur);
    logic [16:0]     q;
    longint unsigned rem;
    q   = '0;
    rem = elapsed;
    for (int i = 0; i < FRACTION_BITS_DEF; i++) begin
      q = q << 1;
      if (rem >= dur - rem) begin
        q[0] = 1'b1;
        rem  = rem - (dur - rem);
      end else begin
        rem = rem + rem;
      end
    end
    return q;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_at(logic [LEVEL_W-1:0] lo,
                                                  logic [LEVEL_W-1:0] hi,
                                                  logic [16:0] t);
    longint v;
    longint lvl;
    v = longint'(lo) * (longint'(1) << FRACTION_BITS_DEF)
        + longint'(t) * (longint'(hi) - longint'(lo));
    if (v < 0) v = 0;
    lvl = v >>> FRACTION_BITS_DEF;
    return (lvl > longint'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(lvl);
  endfunction

  function automatic string fmt_result(out_t r);
    return $sformatf("targets=%h mode=%0d alpha=%0d/%0d bright=%0d last=%0b",
                     r.enabled_targets, r.active_mode, r.alpha_first, r.alpha_second,
                     r.brightness, r.last_result);
  endfunction

  task automatic apply_write(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
    case (reg_idx_t'(addr[CFG_AW-1:2]))
      REG_FROM_FIRST:  regs.from_level_first  = value[LEVEL_W-1:0];
      REG_TO_FIRST:    regs.to_level_first    = value[LEVEL_W-1:0];
      REG_FROM_SECOND: regs.from_level_second = value[LEVEL_W-1:0];
      REG_TO_SECOND:   regs.to_level_second   = value[LEVEL_W-1:0];
      REG_DURATION:    regs.fade_duration     = value[NOW_W-1:0];
      REG_MODE:        regs.blend_mode        = value[1:0];
      REG_DIRECTION:   regs.start_direction   = value[1:0];
      REG_TARGETS:     regs.target_mask       = value[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_fade(in_t item);
    logic [NOW_W-1:0]   elapsed;
    logic               done;
    logic [16:0]        t;
    logic [LEVEL_W-1:0] v1;
    logic [LEVEL_W-1:0] v2;
    out_t               r;
    case (opcode_t'(item.opcode))
      OP_START: begin
        fade_start = item.now_time;
        fade_dir   = direction_t'(regs.start_direction);
        fade_armed = 1'b1;
      end
      OP_STOP: begin
        fade_armed    = 1'b0;
        r             = '0;
        r.last_result = 1'b1;
        blend_q.push_back(r);
      end
      OP_TICK: if (fade_armed) begin
        elapsed = item.now_time - fade_start;
        done    = elapsed >= regs.fade_duration;
        t = done ? (17'(1) << FRACTION_BITS_DEF)
                 : time_fraction(elapsed, regs.fade_duration);
        v1 = level_at(regs.from_level_first, regs.to_level_first, t);
        v2 = level_at(regs.from_level_second, regs.to_level_second, t);
        // "from" directions count down from full level
        if (fade_dir == DIR_FROM || fade_dir == DIR_FROM_BACK) begin
          v1 = LEVEL_MAX - v1;
          v2 = LEVEL_MAX - v2;
        end
        r                 = '0;
        r.enabled_targets = regs.target_mask;
        r.active_mode     = regs.blend_mode;
        if (blend_mode_t'(regs.blend_mode) == MODE_COEF) begin
          r.alpha_first  = v1;
          r.alpha_second = v2;
        end else begin
          r.brightness = v1;
        end
        r.last_result = 1'b1;
        if (done && (fade_dir == DIR_TO || fade_dir == DIR_FROM)) begin
          // plain fade ends: final levels, then a cleared transfer
          r.last_result = 1'b0;
          blend_q.push_back(r);
          r             = '0;
          r.last_result = 1'b1;
          fade_armed    = 1'b0;
        end else if (done) begin
          fade_dir   = (fade_dir == DIR_TO_BACK) ? DIR_FROM : DIR_TO;
          fade_start = item.now_time;
        end
        blend_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      regs.from_level_first  = '0;
      regs.to_level_first    = LEVEL_MAX;
      regs.from_level_second = '0;
      regs.to_level_second   = LEVEL_MAX;
      regs.fade_duration     = 32'h0001_0000;
      regs.blend_mode        = MODE_NONE;
      regs.start_direction   = DIR_TO;
      regs.target_mask       = '0;
      fade_start             = '0;
      fade_dir               = DIR_TO;
      fade_armed             = 1'b0;
      blend_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
      if (in_valid && !in_stall) predict_fade(in_data);
      if (out_valid && !out_stall) begin
        if (blend_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transfer: %s", fmt_result(out_data));
        end else begin
          want = blend_q.pop_front();
          if (out_data.enabled_targets !== want.enabled_targets ||
              out_data.active_mode     !== want.active_mode     ||
              out_data.alpha_first     !== want.alpha_first     ||
              out_data.alpha_second    !== want.alpha_second    ||
              out_data.brightness      !== want.brightness      ||
              out_data.last_result     !== want.last_result) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(out_data));
            end
          end
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= blend_q.size();
  end

endmodule

FILE: bench/blend_fade_sequencer_top_tb.sv
// testbench top for the blend fade sequencer: clock, reset, register setup,
// directed and random input transfers with random idling on both channels
// depends on bfs_pkg, blend_fade_sequencer_top and bfs_fade_checker
`timescale 1ns / 1ps
module blend_fade_sequencer_top_tb;
  import bfs_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 150;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  bit calm       = 1'b0;
  bit hold_req   = 1'b0;

  blend_fade_sequencer_top i_dut (.*);

  bfs_fade_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly short gaps, a few long ones, none in calm phases
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side stall, with one long hold-off on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        n = idle_len();
        out_stall <= (n > 0);
        if (n > 0) repeat (n) @(posedge clk);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(cfg_t c);
    write_reg(REG_FROM_FIRST,  CFG_DW'(c.from_level_first));
    write_reg(REG_TO_FIRST,    CFG_DW'(c.to_level_first));
    write_reg(REG_FROM_SECOND, CFG_DW'(c.from_level_second));
    write_reg(REG_TO_SECOND,   CFG_DW'(c.to_level_second));
    write_reg(REG_DURATION,    CFG_DW'(c.fade_duration));
    write_reg(REG_MODE,        CFG_DW'(c.blend_mode));
    write_reg(REG_DIRECTION,   CFG_DW'(c.start_direction));
    write_reg(REG_TARGETS,     CFG_DW'(c.target_mask));
  endtask

  task automatic offer(opcode_t op, logic [NOW_W-1:0] stamp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data.opcode   <= op;
    in_data.now_time <= stamp;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // wait for every expected result, then let a start or ignored item finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return LEVEL_MAX;
    if (r < 50) return LEVEL_W'($urandom_range(17, 31));
    return LEVEL_W'($urandom_range(0, 16));
  endfunction

  function automatic logic [NOW_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return NOW_W'($urandom_range(1, 4));
    if (r < 55) return NOW_W'($urandom_range(1, 32'h0004_0000));
    if (r < 85) return NOW_W'($urandom_range(32'h0001_0000, 32'h0040_0000));
    if (r < 95) return NOW_W'($urandom_range(1, 32'hFFFF_FFFF));
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [NOW_W-1:0] step_len(logic [NOW_W-1:0] dur);
    longint unsigned span;
    span = 64'(dur) / 3 + 2;
    if ($urandom_range(0, 9) == 0) return dur;
    return NOW_W'({$urandom, $urandom} % span);
  endfunction

  task automatic fade_sequence(logic [NOW_W-1:0] dur);
    logic [NOW_W-1:0] stamp;
    int               n;
    stamp = $urandom;
    n     = $urandom_range(2, 12);
    offer(OP_START, stamp);
    repeat (n) begin
      stamp = stamp + step_len(dur);
      offer(OP_TICK, stamp);
    end
    if ($urandom_range(0, 4) == 0) offer(OP_STOP, stamp);
  endtask

  task automatic run_phase(int quota, logic [NOW_W-1:0] dur);
    int sent0;
    int r;
    sent0 = items_sent;
    while (items_sent - sent0 < quota) begin
      r = $urandom_range(0, 99);
      if (r < 75)      fade_sequence(dur);
      else if (r < 85) offer(OP_TICK, $urandom);
      else if (r < 92) offer(OP_STOP, $urandom);
      else if (r < 95) offer(OP_RSVD, $urandom);
      else             offer(OP_START, $urandom);
    end
  endtask

  initial begin
    cfg_t setup;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // alpha mode, plain fade to, elapsed time wrapping past zero
    setup.from_level_first  = '0;
    setup.to_level_first    = LEVEL_MAX;
    setup.from_level_second = LEVEL_MAX;
    setup.to_level_second   = '0;
    setup.fade_duration     = 32'h0001_0000;
    setup.blend_mode        = MODE_COEF;
    setup.start_direction   = DIR_TO;
    setup.target_mask       = 14'h3FFF;
    load_setup(setup);
    offer(OP_TICK, 32'h0000_0000);
    offer(OP_RSVD, 32'hFFFF_FFFF);
    offer(OP_STOP, 32'hFFFF_FFFF);
    offer(OP_START, 32'hFFFF_0000);
    offer(OP_TICK, 32'hFFFF_0000);
    offer(OP_TICK, 32'hFFFF_8000);
    offer(OP_TICK, 32'h0000_0000);
    offer(OP_TICK, 32'h0000_0005);
    offer(OP_START, 32'h0000_0000);
    offer(OP_START, 32'h0000_0100);
    offer(OP_TICK, 32'h0000_4100);
    offer(OP_STOP, 32'h0000_5000);
    settle();

    // zero duration with levels above full scale, from and back
    setup.from_level_first  = 5'd31;
    setup.to_level_first    = 5'd31;
    setup.from_level_second = '0;
    setup.to_level_second   = 5'd31;
    setup.fade_duration     = '0;
    setup.start_direction   = DIR_FROM_BACK;
    setup.target_mask       = 14'h1555;
    load_setup(setup);
    offer(OP_START, 32'h0001_2345);
    offer(OP_TICK, 32'h0001_2345);
    offer(OP_TICK, 32'h0001_234C);
    offer(OP_TICK, 32'h0000_0000);
    offer(OP_STOP, 32'h0000_0000);
    settle();

    // longest duration, darken, to and back
    setup.from_level_first  = LEVEL_MAX;
    setup.to_level_first    = '0;
    setup.from_level_second = 5'd5;
    setup.to_level_second   = 5'd9;
    setup.fade_duration     = 32'hFFFF_FFFF;
    setup.blend_mode        = MODE_DARKEN;
    setup.start_direction   = DIR_TO_BACK;
    setup.target_mask       = 14'h2AAA;
    load_setup(setup);
    offer(OP_START, 32'h0000_0000);
    offer(OP_TICK, 32'hFFFF_FFFF);
    offer(OP_TICK, 32'h8000_0000);
    offer(OP_STOP, 32'h8000_0000);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      calm                    = (p % 4 == 3);
      setup.from_level_first  = pick_level();
      setup.to_level_first    = pick_level();
      setup.from_level_second = pick_level();
      setup.to_level_second   = pick_level();
      setup.fade_duration     = pick_duration();
      setup.blend_mode        = 2'($urandom_range(0, 3));
      setup.start_direction   = 2'($urandom_range(0, 3));
      setup.target_mask       = MASK_W'($urandom);
      load_setup(setup);
      if (p == 1) hold_req = 1'b1;
      run_phase(PHASE_ITEMS, setup.fade_duration);
      settle();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/bfs_pkg.sv
hdl/bfs_regs.sv
hdl/blend_fade_sequencer_top.sv
bench/bfs_fade_checker.sv
bench/blend_fade_sequencer_top_tb.sv
